// File: hw/rtl/bpps_pkg.sv
`timescale 1ns / 1ps

package bpps_pkg;

   localparam int LEN_W       = 17;
   localparam int LEVEL_W     = 6;
   localparam int RUN_MIN_W   = 7;
   localparam int CUR_W       = 14;
   localparam int SEC_W       = 6;
   localparam int MIN_W       = 8;
   localparam int ACTION_W    = 3;
   localparam int STATUS_W    = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = LEN_W;

   localparam int SAMPLE_BITS_DEFAULT = 10;

   localparam int CUR_LIMIT_RESET = 4500;
   localparam int SAMPLE_MULT     = 15;
   localparam int CUR_MAX         = 16383;
   localparam int SEC_MAX         = 59;
   localparam int MIN_MAX         = 255;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_POS      = 3'd1,
      PH_POS_REST = 3'd2,
      PH_NEG      = 3'd3,
      PH_NEG_REST = 3'd4
   } phase_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_IDLE   = 3'd0,
      ST_RUN    = 3'd1,
      ST_FINISH = 3'd2,
      ST_STOP   = 3'd3,
      ST_TRIP   = 3'd4
   } status_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_TICK_US  = 3'd0,
      ACT_TICK_SEC = 3'd1,
      ACT_START    = 3'd2,
      ACT_STOP     = 3'd3,
      ACT_SAMPLE   = 3'd4
   } action_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_POS_PULSE     = 3'd0,
      REG_POS_REST      = 3'd1,
      REG_NEG_PULSE     = 3'd2,
      REG_NEG_REST      = 3'd3,
      REG_POS_LEVEL     = 3'd4,
      REG_NEG_LEVEL     = 3'd5,
      REG_RUN_MINUTES   = 3'd6,
      REG_CURRENT_LIMIT = 3'd7
   } csr_index_type;

endpackage

// File: hw/rtl/bipolar_pulse_plating_sequencer_top.sv
`timescale 1ns / 1ps

// Pulse-reverse plating sequencer.
// Input channel (req_*): one beat per event: microsecond tick, second tick,
// start, stop key or a current sample (req_sample is used with the sample code).
// Result channel (rsp_*): exactly one beat per input beat, in order, carrying
// the pulse outputs, drive level, conversion request, run clock, latched
// current and run status as they stand after that event.
// Configuration (csr_*): one register written per cycle with csr_write_en;
// write only while the block holds no beat in flight.
// An accepted input beat goes first into the input register, then the whole
// state update is done in one pass into the result register. Throughput is
// one beat per cycle while rsp_stall is low, since the state update is
// combinational.
// When rsp_stall is high the result register holds; the input register still
// takes one more beat, after which req_stall rises until the result moves on.
// Reset clears the sequencer to idle with the run clock and current at zero,
// the phase lengths, levels and run length at zero and the current limit at
// 4500. The block accepts beats as soon as reset is released.

module bipolar_pulse_plating_sequencer_top #(
   parameter int SAMPLE_BITS = bpps_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bpps_pkg::ACTION_W-1:0]     req_action,
   input  logic [SAMPLE_BITS-1:0]            req_sample,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_pulse_pos,
   output logic                              rsp_pulse_neg,
   output logic [bpps_pkg::LEVEL_W-1:0]      rsp_drive_level,
   output logic                              rsp_sample_request,
   output logic [bpps_pkg::MIN_W-1:0]        rsp_run_min,
   output logic [bpps_pkg::SEC_W-1:0]        rsp_run_sec,
   output logic [bpps_pkg::CUR_W-1:0]        rsp_current_scaled,
   output logic [bpps_pkg::STATUS_W-1:0]     rsp_status,

   input  logic                              csr_write_en,
   input  logic [bpps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [bpps_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import bpps_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + 4;
   localparam int EXT_W  = (PROD_W > CUR_W) ? PROD_W : CUR_W;

   // Configuration registers
   logic [LEN_W-1:0]     len_ff [4];
   logic [LEVEL_W-1:0]   pos_level_ff;
   logic [LEVEL_W-1:0]   neg_level_ff;
   logic [RUN_MIN_W-1:0] run_minutes_ff;
   logic [CUR_W-1:0]     current_limit_ff;

   // Input register
   logic                 in_valid_ff, in_valid_in;
   logic [ACTION_W-1:0]  in_action_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;

   // Sequencer state
   phase_type            phase_ff, phase_in;
   logic [LEN_W-1:0]     count_ff, count_in;
   logic [SEC_W-1:0]     sec_ff, sec_in;
   logic [MIN_W-1:0]     min_ff, min_in;
   logic [SEC_W-1:0]     latched_sec_ff, latched_sec_in;
   logic [CUR_W-1:0]     current_ff, current_in;
   logic [SAMPLE_BITS-1:0] pending_ff, pending_in;
   logic                 sample_valid_ff, sample_valid_in;
   logic                 stop_ff, stop_in;
   status_type           status_ff, status_in;
   logic                 sample_req_in;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_pulse_pos_ff, rsp_pulse_pos_in;
   logic                 rsp_pulse_neg_ff, rsp_pulse_neg_in;
   logic [LEVEL_W-1:0]   rsp_level_ff, rsp_level_in;
   logic                 rsp_sample_req_ff;
   logic [MIN_W-1:0]     rsp_min_ff;
   logic [SEC_W-1:0]     rsp_sec_ff;
   logic [CUR_W-1:0]     rsp_current_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   logic                 advance;
   logic                 process;
   logic                 running;
   logic [LEN_W-1:0]     count_inc;
   logic [LEN_W-1:0]     cur_len;
   logic [3:0]           len_nz;
   logic                 after_found;
   phase_type            after_phase;
   logic                 any_found;
   phase_type            any_phase;
   logic [PROD_W-1:0]    prod;
   logic [EXT_W-1:0]     prod_ext;
   logic [CUR_W-1:0]     prod_sat;
   logic                 do_period;

   // Handshake: the input register refills whenever its beat moves on.
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign process     = in_valid_ff && advance;
   assign req_stall   = in_valid_ff && !advance;
   assign in_valid_in = (req_valid && !req_stall) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? in_valid_ff : rsp_valid_ff;

   assign running   = (status_ff == ST_RUN);
   assign count_inc = count_ff + LEN_W'(1);

   always_comb begin
      case (phase_ff)
         PH_POS:      cur_len = len_ff[0];
         PH_POS_REST: cur_len = len_ff[1];
         PH_NEG:      cur_len = len_ff[2];
         PH_NEG_REST: cur_len = len_ff[3];
         default:     cur_len = '0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         len_nz[i] = (len_ff[i] != '0);
      end
   end

   // First nonzero phase after the current one, and first nonzero phase overall.
   always_comb begin
      after_found = 1'b0;
      after_phase = PH_NEG_REST;
      any_found   = 1'b0;
      any_phase   = PH_NEG_REST;
      for (int q = 0; q < 4; q++) begin
         if (!after_found && len_nz[q] && (3'(q + 1) > 3'(phase_ff))) begin
            after_found = 1'b1;
            after_phase = phase_type'(3'(q + 1));
         end
         if (!any_found && len_nz[q]) begin
            any_found = 1'b1;
            any_phase = phase_type'(3'(q + 1));
         end
      end
   end

   // Scaled current candidate, saturated to the field width.
   assign prod     = PROD_W'(pending_ff) * PROD_W'(SAMPLE_MULT);
   assign prod_ext = EXT_W'(prod);
   assign prod_sat = (prod_ext > EXT_W'(CUR_MAX)) ? CUR_W'(CUR_MAX) : prod_ext[CUR_W-1:0];

   // Next-state logic
   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      sec_in          = sec_ff;
      min_in          = min_ff;
      latched_sec_in  = latched_sec_ff;
      current_in      = current_ff;
      pending_in      = pending_ff;
      sample_valid_in = sample_valid_ff;
      stop_in         = stop_ff;
      status_in       = status_ff;
      sample_req_in   = 1'b0;
      do_period       = 1'b0;

      case (action_type'(in_action_ff))
         ACT_TICK_US: begin
            if (running && phase_ff != PH_IDLE) begin
               count_in = count_inc;
               if (count_inc >= cur_len || count_inc == '0) begin
                  sample_req_in = (phase_ff == PH_POS) || (phase_ff == PH_NEG);
                  if (after_found) begin
                     phase_in = after_phase;
                     count_in = '0;
                  end else begin
                     do_period = 1'b1;
                  end
               end
            end
         end
         ACT_TICK_SEC: begin
            if (running) begin
               if (sec_ff < SEC_W'(SEC_MAX)) begin
                  sec_in = sec_ff + SEC_W'(1);
               end else begin
                  sec_in = '0;
                  if (min_ff != MIN_W'(MIN_MAX)) begin
                     min_in = min_ff + MIN_W'(1);
                  end
               end
            end
         end
         ACT_START: begin
            if (!running) begin
               status_in       = ST_RUN;
               sec_in          = '0;
               min_in          = '0;
               current_in      = '0;
               pending_in      = '0;
               sample_valid_in = 1'b0;
               stop_in         = 1'b0;
               do_period       = 1'b1;
            end
         end
         ACT_STOP: begin
            if (running) begin
               stop_in = 1'b1;
            end
         end
         ACT_SAMPLE: begin
            pending_in      = in_sample_ff;
            sample_valid_in = 1'b1;
         end
         default: begin
         end
      endcase

      // Period start: latch the current once per second, then check the run ends.
      if (do_period) begin
         if (latched_sec_ff != sec_in) begin
            latched_sec_in = sec_in;
            if (sample_valid_in) begin
               current_in      = prod_sat;
               sample_valid_in = 1'b0;
               pending_in      = '0;
            end
         end
         count_in = '0;
         if (current_in >= current_limit_ff) begin
            status_in = ST_TRIP;
            phase_in  = PH_IDLE;
            stop_in   = 1'b0;
            sec_in    = '0;
            min_in    = '0;
         end else if (stop_in) begin
            status_in = ST_STOP;
            phase_in  = PH_IDLE;
            stop_in   = 1'b0;
            sec_in    = '0;
            min_in    = '0;
         end else if (min_in >= MIN_W'(run_minutes_ff)) begin
            status_in = ST_FINISH;
            phase_in  = PH_IDLE;
            stop_in   = 1'b0;
         end else begin
            phase_in = any_found ? any_phase : PH_NEG_REST;
         end
      end
   end

   // Result outputs from the updated state
   always_comb begin
      rsp_pulse_pos_in = (status_in == ST_RUN) && (phase_in == PH_POS);
      rsp_pulse_neg_in = (status_in == ST_RUN) && (phase_in == PH_NEG);
      if (rsp_pulse_pos_in) begin
         rsp_level_in = pos_level_ff;
      end else if (rsp_pulse_neg_in) begin
         rsp_level_in = neg_level_ff;
      end else begin
         rsp_level_in = '0;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 4; i++) begin
            len_ff[i] <= '0;
         end
         pos_level_ff     <= '0;
         neg_level_ff     <= '0;
         run_minutes_ff   <= '0;
         current_limit_ff <= CUR_W'(CUR_LIMIT_RESET);
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            REG_POS_PULSE:     len_ff[0]        <= csr_wdata;
            REG_POS_REST:      len_ff[1]        <= csr_wdata;
            REG_NEG_PULSE:     len_ff[2]        <= csr_wdata;
            REG_NEG_REST:      len_ff[3]        <= csr_wdata;
            REG_POS_LEVEL:     pos_level_ff     <= csr_wdata[LEVEL_W-1:0];
            REG_NEG_LEVEL:     neg_level_ff     <= csr_wdata[LEVEL_W-1:0];
            REG_RUN_MINUTES:   run_minutes_ff   <= csr_wdata[RUN_MIN_W-1:0];
            REG_CURRENT_LIMIT: current_limit_ff <= csr_wdata[CUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         phase_ff        <= PH_IDLE;
         count_ff        <= '0;
         sec_ff          <= '0;
         min_ff          <= '0;
         latched_sec_ff  <= '0;
         current_ff      <= '0;
         pending_ff      <= '0;
         sample_valid_ff <= 1'b0;
         stop_ff         <= 1'b0;
         status_ff       <= ST_IDLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (process) begin
            phase_ff        <= phase_in;
            count_ff        <= count_in;
            sec_ff          <= sec_in;
            min_ff          <= min_in;
            latched_sec_ff  <= latched_sec_in;
            current_ff      <= current_in;
            pending_ff      <= pending_in;
            sample_valid_ff <= sample_valid_in;
            stop_ff         <= stop_in;
            status_ff       <= status_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_action_ff <= req_action;
         in_sample_ff <= req_sample;
      end
      if (process) begin
         rsp_pulse_pos_ff  <= rsp_pulse_pos_in;
         rsp_pulse_neg_ff  <= rsp_pulse_neg_in;
         rsp_level_ff      <= rsp_level_in;
         rsp_sample_req_ff <= sample_req_in;
         rsp_min_ff        <= min_in;
         rsp_sec_ff        <= sec_in;
         rsp_current_ff    <= current_in;
         rsp_status_ff     <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pulse_pos      = rsp_pulse_pos_ff;
   assign rsp_pulse_neg      = rsp_pulse_neg_ff;
   assign rsp_drive_level    = rsp_level_ff;
   assign rsp_sample_request = rsp_sample_req_ff;
   assign rsp_run_min        = rsp_min_ff;
   assign rsp_run_sec        = rsp_sec_ff;
   assign rsp_current_scaled = rsp_current_ff;
   assign rsp_status         = rsp_status_ff;

   // A phase is active exactly while the run is in progress.
   assert property (@(posedge clock) disable iff (reset)
      (status_ff == ST_RUN) == (phase_ff != PH_IDLE))
      else $error("phase and run status disagree");

   // A trip or a stop leaves the run clock cleared.
   assert property (@(posedge clock) disable iff (reset)
      (status_ff == ST_TRIP || status_ff == ST_STOP) |-> (sec_ff == '0 && min_ff == '0))
      else $error("run clock not cleared after trip or stop");

   // Both polarities are never driven in the same result beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_pulse_pos_ff && rsp_pulse_neg_ff))
      else $error("both pulse outputs active");

   // A nonzero drive level only appears during a pulse of a running block.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_level_ff != '0) |->
         ((rsp_pulse_pos_ff || rsp_pulse_neg_ff) && rsp_status_ff == ST_RUN))
      else $error("drive level outside a pulse");

   // A stalled result beat is not overwritten by the beat behind it.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_status_ff)))
      else $error("stalled result beat changed");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import bpps_pkg::*;

   localparam int SAMPLE_W       = SAMPLE_BITS_DEFAULT;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int LONG_HOLD      = 40;

   typedef struct packed {
      logic                pulse_pos;
      logic                pulse_neg;
      logic [LEVEL_W-1:0]  drive_level;
      logic                sample_request;
      logic [MIN_W-1:0]    run_min;
      logic [SEC_W-1:0]    run_sec;
      logic [CUR_W-1:0]    current_scaled;
      logic [STATUS_W-1:0] status;
   } seq_beat_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [ACTION_W-1:0]    req_action;
   logic [SAMPLE_W-1:0]    req_sample;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_pulse_pos;
   logic                   rsp_pulse_neg;
   logic [LEVEL_W-1:0]     rsp_drive_level;
   logic                   rsp_sample_request;
   logic [MIN_W-1:0]       rsp_run_min;
   logic [SEC_W-1:0]       rsp_run_sec;
   logic [CUR_W-1:0]       rsp_current_scaled;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   bipolar_pulse_plating_sequencer_top DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_sample         (req_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pulse_pos      (rsp_pulse_pos),
      .rsp_pulse_neg      (rsp_pulse_neg),
      .rsp_drive_level    (rsp_drive_level),
      .rsp_sample_request (rsp_sample_request),
      .rsp_run_min        (rsp_run_min),
      .rsp_run_sec        (rsp_run_sec),
      .rsp_current_scaled (rsp_current_scaled),
      .rsp_status         (rsp_status),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // Sequencer model state and its copy of the registers.
   logic [LEN_W-1:0]     len_cfg [4];
   logic [LEVEL_W-1:0]   pos_lvl;
   logic [LEVEL_W-1:0]   neg_lvl;
   logic [RUN_MIN_W-1:0] run_min_cfg;
   logic [CUR_W-1:0]     cur_limit;

   phase_type            seq_phase;
   logic [LEN_W-1:0]     phase_cnt;
   logic [SEC_W-1:0]     clk_sec;
   logic [MIN_W-1:0]     clk_min;
   logic [SEC_W-1:0]     latched_sec;
   logic [CUR_W-1:0]     cur_value;
   logic [SAMPLE_W-1:0]  pend_sample;
   bit                   sample_ok;
   bit                   stop_req;
   status_type           run_state;

   seq_beat_type         expected_beats [$];
   int                   mismatch_count;
   int                   idle_cycles;
   int                   send_idle_pct;
   int                   recv_stall_pct;
   int                   hold_left;

   function automatic logic [LEN_W-1:0] len_of(phase_type p);
      if (p >= PH_POS && p <= PH_NEG_REST) return len_cfg[int'(p) - 1];
      return '0;
   endfunction

   function automatic void end_run(status_type st, bit clear_clock);
      run_state = st;
      seq_phase = PH_IDLE;
      phase_cnt = '0;
      stop_req  = 0;
      if (clear_clock) begin
         clk_sec = '0;
         clk_min = '0;
      end
   endfunction

   // Latches the current on a new second, then decides whether the run goes on.
   function automatic bit period_boundary();
      int unsigned prod;
      if (latched_sec != clk_sec) begin
         latched_sec = clk_sec;
         if (sample_ok) begin
            prod        = pend_sample * SAMPLE_MULT;
            cur_value   = (prod > CUR_MAX) ? CUR_W'(CUR_MAX) : CUR_W'(prod);
            sample_ok   = 0;
            pend_sample = '0;
         end
      end
      if (cur_value >= cur_limit) begin
         end_run(ST_TRIP, 1);
         return 0;
      end
      if (stop_req) begin
         end_run(ST_STOP, 1);
         return 0;
      end
      if (clk_min >= run_min_cfg) begin
         end_run(ST_FINISH, 0);
         return 0;
      end
      return 1;
   endfunction

   function automatic void enter_phase_from(int first);
      int q;
      for (q = first; q <= int'(PH_NEG_REST); q++) begin
         if (len_of(phase_type'(q)) != 0) begin
            seq_phase = phase_type'(q);
            phase_cnt = '0;
            return;
         end
      end
      if (!period_boundary()) return;
      for (q = int'(PH_POS); q <= int'(PH_NEG_REST); q++) begin
         if (len_of(phase_type'(q)) != 0) begin
            seq_phase = phase_type'(q);
            phase_cnt = '0;
            return;
         end
      end
      // Every length is zero: park in the reverse rest.
      seq_phase = PH_NEG_REST;
      phase_cnt = '0;
   endfunction

   function automatic seq_beat_type sequence_event(logic [ACTION_W-1:0] act,
                                                   logic [SAMPLE_W-1:0] smp);
      seq_beat_type r;
      bit           running;
      bit           conv_req;
      phase_type    prev;
      conv_req = 0;
      running  = (run_state == ST_RUN);
      case (act)
         ACT_TICK_US: begin
            if (running && seq_phase != PH_IDLE) begin
               phase_cnt = phase_cnt + 1'b1;
               if (phase_cnt >= len_of(seq_phase) || phase_cnt == 0) begin
                  prev = seq_phase;
                  if (prev == PH_POS || prev == PH_NEG) conv_req = 1;
                  enter_phase_from(int'(prev) + 1);
               end
            end
         end
         ACT_TICK_SEC: begin
            if (running) begin
               if (clk_sec < SEC_MAX) clk_sec = clk_sec + 1'b1;
               else begin
                  clk_sec = '0;
                  if (clk_min < MIN_MAX) clk_min = clk_min + 1'b1;
               end
            end
         end
         ACT_START: begin
            if (!running) begin
               run_state   = ST_RUN;
               clk_sec     = '0;
               clk_min     = '0;
               cur_value   = '0;
               pend_sample = '0;
               sample_ok   = 0;
               stop_req    = 0;
               seq_phase   = PH_IDLE;
               phase_cnt   = '0;
               enter_phase_from(int'(PH_NEG_REST) + 1);
            end
         end
         ACT_STOP: begin
            if (running) stop_req = 1;
         end
         ACT_SAMPLE: begin
            pend_sample = smp;
            sample_ok   = 1;
         end
         default: ;
      endcase
      running          = (run_state == ST_RUN);
      r.pulse_pos      = running && seq_phase == PH_POS;
      r.pulse_neg      = running && seq_phase == PH_NEG;
      r.drive_level    = r.pulse_pos ? pos_lvl : (r.pulse_neg ? neg_lvl : '0);
      r.sample_request = conv_req;
      r.run_min        = clk_min;
      r.run_sec        = clk_sec;
      r.current_scaled = cur_value;
      r.status         = run_state;
      return r;
   endfunction

   initial clock = 0;
   always #5 clock = ~clock;

   // Both channels are observed here: results are checked, accepted events predicted.
   always @(posedge clock) begin
      seq_beat_type want;
      seq_beat_type got;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.pulse_pos      = rsp_pulse_pos;
            got.pulse_neg      = rsp_pulse_neg;
            got.drive_level    = rsp_drive_level;
            got.sample_request = rsp_sample_request;
            got.run_min        = rsp_run_min;
            got.run_sec        = rsp_run_sec;
            got.current_scaled = rsp_current_scaled;
            got.status         = rsp_status;
            if (expected_beats.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result beat at %0t", $realtime);
            end else begin
               want = expected_beats.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch at %0t: expected pos=%0d neg=%0d lvl=%0d req=%0d min=%0d sec=%0d cur=%0d st=%0d",
                              $realtime, want.pulse_pos, want.pulse_neg,
                              want.drive_level, want.sample_request, want.run_min,
                              want.run_sec, want.current_scaled, want.status);
                     $display("   got pos=%0d neg=%0d lvl=%0d req=%0d min=%0d sec=%0d cur=%0d st=%0d",
                              got.pulse_pos, got.pulse_neg, got.drive_level,
                              got.sample_request, got.run_min, got.run_sec,
                              got.current_scaled, got.status);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            expected_beats.push_back(sequence_event(req_action, req_sample));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("bipolar_pulse_plating_sequencer_top verification failed");
            $finish;
         end
      end
   end

   // The long hold-off is counted down here; otherwise the receiver stalls at random.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_stall = 1;
         hold_left = hold_left - 1;
      end else
         rsp_stall = ($urandom_range(99) < recv_stall_pct);
   end

   task automatic offer_event(logic [ACTION_W-1:0] act, logic [SAMPLE_W-1:0] smp);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid  = 1;
      req_action = act;
      req_sample = smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid = 0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int unsigned value);
      @(negedge clock);
      csr_write_en = 1;
      csr_index    = idx;
      csr_wdata    = CSR_DATA_W'(value);
      case (idx)
         REG_POS_PULSE, REG_POS_REST, REG_NEG_PULSE, REG_NEG_REST:
            len_cfg[int'(idx)] = LEN_W'(value);
         REG_POS_LEVEL:     pos_lvl     = LEVEL_W'(value);
         REG_NEG_LEVEL:     neg_lvl     = LEVEL_W'(value);
         REG_RUN_MINUTES:   run_min_cfg = RUN_MIN_W'(value);
         REG_CURRENT_LIMIT: cur_limit   = CUR_W'(value);
         default: ;
      endcase
      @(negedge clock);
      csr_write_en = 0;
   endtask

   task automatic write_lengths(int unsigned pp, int unsigned pr, int unsigned np,
                                int unsigned nr);
      write_reg(REG_POS_PULSE, pp);
      write_reg(REG_POS_REST, pr);
      write_reg(REG_NEG_PULSE, np);
      write_reg(REG_NEG_REST, nr);
   endtask

   function automatic int unsigned pick_length();
      int r;
      r = $urandom_range(99);
      if (r < 25) return 0;
      if (r < 85) return $urandom_range(1, 6);
      if (r < 95) return $urandom_range(7, 40);
      return 127500;
   endfunction

   function automatic logic [ACTION_W-1:0] pick_action(int sec_pct);
      int r;
      if ($urandom_range(99) < sec_pct) return ACT_TICK_SEC;
      r = $urandom_range(99);
      if (r < 65) return ACT_TICK_US;
      if (r < 80) return ACT_SAMPLE;
      if (r < 88) return ACT_START;
      if (r < 94) return ACT_STOP;
      return ACTION_W'($urandom_range(5, 7));
   endfunction

   task automatic randomize_registers();
      int r;
      write_lengths(pick_length(), pick_length(), pick_length(), pick_length());
      write_reg(REG_POS_LEVEL, ($urandom_range(9) == 0) ? 63 : $urandom_range(0, 39));
      write_reg(REG_NEG_LEVEL, ($urandom_range(9) == 0) ? 63 : $urandom_range(0, 39));
      r = $urandom_range(99);
      write_reg(REG_RUN_MINUTES, (r < 20) ? 0 : (r < 80) ? 1 : (r < 90) ? 2 : 120);
      r = $urandom_range(99);
      write_reg(REG_CURRENT_LIMIT, (r < 25) ? CUR_MAX : (r < 35) ? 0 :
                (r < 60) ? CUR_LIMIT_RESET : $urandom_range(0, CUR_MAX));
   endtask

   task automatic test_idle_events();
      offer_event(ACT_SAMPLE, '0);
      offer_event(ACT_TICK_US, '1);
      offer_event(ACT_TICK_SEC, '0);
      offer_event(ACT_STOP, '1);
      offer_event(ACT_TICK_US + 3'd5, '0);
      offer_event(ACT_TICK_US + 3'd6, '1);
      offer_event(ACT_TICK_US + 3'd7, '0);
      wait_drained();
   endtask

   task automatic test_zero_minute_finish();
      offer_event(ACT_START, '0);
      offer_event(ACT_TICK_US, '0);
      wait_drained();
   endtask

   // With every length zero each microsecond tick is a period start.
   task automatic test_parked_period();
      write_reg(REG_RUN_MINUTES, 1);
      write_reg(REG_CURRENT_LIMIT, CUR_MAX);
      offer_event(ACT_START, '0);
      offer_event(ACT_TICK_US, '0);
      offer_event(ACT_START, '0);
      offer_event(ACT_SAMPLE, '1);
      offer_event(ACT_TICK_SEC, '0);
      offer_event(ACT_TICK_US, '0);
      offer_event(ACT_STOP, '0);
      offer_event(ACT_TICK_US, '0);
      wait_drained();
   endtask

   task automatic test_trip_and_levels();
      write_lengths(1, 0, 2, 1);
      write_reg(REG_POS_LEVEL, 39);
      write_reg(REG_NEG_LEVEL, 63);
      write_reg(REG_RUN_MINUTES, 120);
      write_reg(REG_CURRENT_LIMIT, 0);
      offer_event(ACT_START, '0);
      wait_drained();
      write_reg(REG_CURRENT_LIMIT, 300);
      offer_event(ACT_START, '0);
      offer_event(ACT_TICK_US, '0);
      offer_event(ACT_TICK_US, '0);
      offer_event(ACT_SAMPLE, 25);
      offer_event(ACT_TICK_SEC, '0);
      repeat (4) offer_event(ACT_TICK_US, '0);
      wait_drained();
   endtask

   // The receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_lengths(2, 1, 3, 1);
      write_reg(REG_CURRENT_LIMIT, CUR_MAX);
      hold_left = LONG_HOLD;
      offer_event(ACT_START, '0);
      repeat (20) offer_event(ACT_TICK_US, '0);
      wait_drained();
   endtask

   task automatic run_random_events(int count, int sec_pct);
      offer_event(ACT_START, SAMPLE_W'($urandom));
      repeat (count - 1)
         offer_event(pick_action(sec_pct), SAMPLE_W'($urandom_range(0, 1023)));
      wait_drained();
   endtask

   task automatic test_random_traffic(int sender_idle, int receiver_stall);
      send_idle_pct  = sender_idle;
      recv_stall_pct = receiver_stall;
      randomize_registers();
      run_random_events(32, 20);
      randomize_registers();
      run_random_events(32, 20);
   endtask

   // Mostly second ticks, so the run clock rolls over into minutes.
   task automatic test_run_clock();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_lengths(pick_length(), pick_length(), 3, 2);
      write_reg(REG_RUN_MINUTES, 1);
      write_reg(REG_CURRENT_LIMIT, CUR_MAX);
      run_random_events(100, 80);
   endtask

   initial begin
      reset          = 1;
      req_valid      = 0;
      req_action     = ACT_TICK_US;
      req_sample     = '0;
      rsp_stall      = 0;
      csr_write_en   = 0;
      csr_index      = REG_POS_PULSE;
      csr_wdata      = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 0;
      mismatch_count = 0;
      idle_cycles    = 0;
      for (int i = 0; i < 4; i++) len_cfg[i] = '0;
      pos_lvl     = '0;
      neg_lvl     = '0;
      run_min_cfg = '0;
      cur_limit   = CUR_W'(CUR_LIMIT_RESET);
      seq_phase   = PH_IDLE;
      phase_cnt   = '0;
      clk_sec     = '0;
      clk_min     = '0;
      latched_sec = '0;
      cur_value   = '0;
      pend_sample = '0;
      sample_ok   = 0;
      stop_req    = 0;
      run_state   = ST_IDLE;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;

      test_idle_events();
      test_zero_minute_finish();
      test_parked_period();
      test_trip_and_levels();
      test_backpressure();
      test_random_traffic(0, 0);
      test_random_traffic(82, 0);
      test_random_traffic(0, 82);
      test_random_traffic(28, 28);
      test_run_clock();

      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("bipolar_pulse_plating_sequencer_top verification clean");
      else
         $display("bipolar_pulse_plating_sequencer_top verification failed");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/bpps_pkg.sv
hw/rtl/bipolar_pulse_plating_sequencer_top.sv
dv/tb.sv
